### rtl/core/u2u_pkg.sv
package u2u_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int BYTE_W             = 8;
    localparam int UNIT_W             = 16;
    localparam int QUEUE_DEPTH        = 4;
    localparam int CFG_ADDR_W         = 3;
    localparam int CFG_DATA_W         = 32;

    localparam logic [UNIT_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [UNIT_W-1:0] SUBST_RESET = 16'hEEEE;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_CONT,
        KIND_BAD
    } byte_kind_t;

    typedef enum logic {
        REG_UNIT_LIMIT = 1'b0,
        REG_SUBSTITUTE = 1'b1
    } reg_index_t;

    typedef struct packed {
        byte_kind_t          kind;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } queue_entry_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_limit;
        logic [UNIT_W-1:0] substitute_unit;
    } cfg_t;

    typedef struct packed {
        logic              has_unit;
        logic [UNIT_W-1:0] code_unit;
        logic              substituted;
        logic              stopped;
        logic              end_of_text;
        logic [UNIT_W-1:0] units_so_far;
    } result_t;

endpackage

### rtl/core/u2u_front.sv
module u2u_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u2u_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    output logic                          push_valid,
    input  logic                          push_ready,
    output u2u_pkg::queue_entry_t         push_entry
);
    import u2u_pkg::*;

    localparam logic [BYTE_W-1:0] MaskTop1  = 8'h80;
    localparam logic [BYTE_W-1:0] MaskTop2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MaskTop3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MaskTop4  = 8'hF0;
    localparam logic [BYTE_W-1:0] CodeCont  = 8'h80;
    localparam logic [BYTE_W-1:0] CodeLead2 = 8'hC0;
    localparam logic [BYTE_W-1:0] CodeLead3 = 8'hE0;

    logic         valid_reg;
    logic         valid_next;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        entry_next.data = s_tdata;
        entry_next.last = s_tlast;
        if ((s_tdata & MaskTop1) == 8'h00)
        begin
            entry_next.kind = KIND_ASCII;
        end
        else if ((s_tdata & MaskTop2) == CodeCont)
        begin
            entry_next.kind = KIND_CONT;
        end
        else if ((s_tdata & MaskTop3) == CodeLead2)
        begin
            entry_next.kind = KIND_LEAD2;
        end
        else if ((s_tdata & MaskTop4) == CodeLead3)
        begin
            entry_next.kind = KIND_LEAD3;
        end
        else
        begin
            entry_next.kind = KIND_BAD;
        end
    end

    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### rtl/core/u2u_queue.sv
module u2u_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  u2u_pkg::queue_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output u2u_pkg::queue_entry_t pop_entry
);
    import u2u_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    queue_entry_t    mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue count exceeds depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FullCnt) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("full queue with unequal pointers");

endmodule

### rtl/core/u2u_back.sv
module u2u_back
#(
    parameter int COUNT_BITS = u2u_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  u2u_pkg::queue_entry_t pop_entry,
    input  u2u_pkg::cfg_t         cfg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u2u_pkg::result_t      result
);
    import u2u_pkg::*;

    localparam int CmpW = (COUNT_BITS > UNIT_W) ? COUNT_BITS : UNIT_W;
    localparam logic [CmpW-1:0] CntMax = CmpW'((64'd1 << COUNT_BITS) - 64'd1);

    logic [1:0]            pending_reg;
    logic [1:0]            pending_next;
    logic [UNIT_W-1:0]     partial_reg;
    logic [UNIT_W-1:0]     partial_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic                  halted_reg;
    logic                  halted_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               result_reg;
    result_t               result_next;

    logic [COUNT_BITS-1:0] count_inc;
    logic [CmpW-1:0]       limit_ext;
    logic [CmpW-1:0]       eff_limit;
    logic                  take;
    logic                  emit;
    logic                  have;
    logic                  sub;
    logic [UNIT_W-1:0]     unit;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign count_inc = count_reg + 1'b1;
    assign limit_ext = CmpW'(cfg.unit_limit);
    assign eff_limit = (limit_ext < CntMax) ? limit_ext : CntMax;

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        bad_next     = bad_reg;
        halted_next  = halted_reg;
        count_next   = count_reg;
        have         = 1'b0;
        sub          = 1'b0;
        unit         = '0;
        if (!halted_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                if (CmpW'(count_reg) >= eff_limit)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    case (pop_entry.kind)
                        KIND_ASCII:
                        begin
                            unit = UNIT_W'(pop_entry.data);
                            have = 1'b1;
                        end
                        KIND_LEAD2:
                        begin
                            partial_next = UNIT_W'(pop_entry.data[4:0]);
                            pending_next = 2'd1;
                            bad_next     = 1'b0;
                        end
                        KIND_LEAD3:
                        begin
                            partial_next = UNIT_W'(pop_entry.data[3:0]);
                            pending_next = 2'd2;
                            bad_next     = 1'b0;
                        end
                        default:
                        begin
                            halted_next = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                if (pop_entry.kind != KIND_CONT)
                begin
                    bad_next = 1'b1;
                end
                partial_next = {partial_reg[UNIT_W-7:0], pop_entry.data[5:0]};
                pending_next = pending_reg - 2'd1;
                if (pending_next == 2'd0)
                begin
                    have = 1'b1;
                    if (bad_next)
                    begin
                        unit = cfg.substitute_unit;
                        sub  = 1'b1;
                    end
                    else
                    begin
                        unit = partial_next;
                    end
                end
            end
            if (!have && pop_entry.last && (pending_next != 2'd0))
            begin
                have         = 1'b1;
                sub          = 1'b1;
                unit         = cfg.substitute_unit;
                pending_next = 2'd0;
            end
            if (have)
            begin
                count_next = count_inc;
                if (CmpW'(count_inc) >= eff_limit)
                begin
                    halted_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        emit                     = have || pop_entry.last;
        result_next.has_unit     = have;
        result_next.code_unit    = unit;
        result_next.substituted  = sub;
        result_next.stopped      = halted_next;
        result_next.end_of_text  = pop_entry.last;
        result_next.units_so_far = UNIT_W'(count_next);
        out_valid_next           = pop_ready ? (take && emit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            bad_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (pop_entry.last)
                begin
                    pending_reg <= 2'd0;
                    partial_reg <= '0;
                    bad_reg     <= 1'b0;
                    halted_reg  <= 1'b0;
                    count_reg   <= '0;
                end
                else
                begin
                    pending_reg <= pending_next;
                    partial_reg <= partial_next;
                    bad_reg     <= bad_next;
                    halted_reg  <= halted_next;
                    count_reg   <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            result_reg <= result_next;
        end
    end

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two continuation bytes pending");

    a_halted_closed: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (pending_reg == 2'd0))
        else $error("decoder halted with a sequence still open");

    a_text_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pop_entry.last) |=>
            ((count_reg == '0) && !halted_reg && (pending_reg == 2'd0) && !bad_reg))
        else $error("text state not cleared after the final byte");

endmodule

### rtl/core/utf8_to_ucs2_stream_decoder.sv
// UTF-8 to UCS-2 stream decoder.
// The slave stream carries one UTF-8 byte per transfer in s_tdata, with
// s_tlast on the final byte of a text. The master stream carries a result
// whenever a code unit completes or the final byte arrives; m_tlast marks
// the result of the final byte, which also reports the unit count.
// Malformed multi-byte sequences, and sequences cut short by the final byte,
// produce the substitute unit from the register at byte address 4. The
// register at address 0 limits the units per text. A stray continuation
// byte, a lead of 0xF0 or above, or reaching the limit stops output until
// the text ends. Write registers only while the block is idle.
// One byte is accepted per cycle while s_tready is high. A byte passes
// through the classifying front stage, the four-entry queue and the decode
// stage, whose output register holds the result. When the receiver stalls,
// the queue and the front stage fill and s_tready drops once both are full.
// Reset empties the pipeline, clears the text state and loads the register
// defaults (limit 65535, substitute 0xEEEE).
module utf8_to_ucs2_stream_decoder
#(
    parameter int COUNT_BITS = u2u_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [u2u_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [u2u_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [u2u_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // text_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // code_unit, units_so_far
    output logic [2:0]                        m_tuser,  // has_unit, substituted, stopped
    output logic                              m_tlast
);
    import u2u_pkg::*;

    logic [UNIT_W-1:0] limit_reg;
    logic [UNIT_W-1:0] limit_next;
    logic [UNIT_W-1:0] subst_reg;
    logic [UNIT_W-1:0] subst_next;
    reg_index_t        reg_index;
    logic              cfg_write;
    cfg_t              cfg;

    logic              push_valid;
    logic              push_ready;
    queue_entry_t      push_entry;
    logic              pop_valid;
    logic              pop_ready;
    queue_entry_t      pop_entry;
    result_t           result;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        limit_next = limit_reg;
        subst_next = subst_reg;
        prdata     = '0;
        case (reg_index)
            REG_UNIT_LIMIT:
            begin
                prdata = CFG_DATA_W'(limit_reg);
                if (cfg_write)
                begin
                    limit_next = pwdata[UNIT_W-1:0];
                end
            end
            REG_SUBSTITUTE:
            begin
                prdata = CFG_DATA_W'(subst_reg);
                if (cfg_write)
                begin
                    subst_next = pwdata[UNIT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            subst_reg <= SUBST_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
            subst_reg <= subst_next;
        end
    end

    assign cfg.unit_limit      = limit_reg;
    assign cfg.substitute_unit = subst_reg;

    u2u_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    u2u_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    u2u_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .cfg        (cfg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = {result.units_so_far, result.code_unit};
    assign m_tuser = {result.stopped, result.substituted, result.has_unit};
    assign m_tlast = result.end_of_text;

endmodule

### tb/sv/ucs2_result_checker.sv
`timescale 1ns / 1ps

module ucs2_result_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [u2u_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [u2u_pkg::CFG_DATA_W-1:0]    pwdata,
    input  logic                              pready,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [31:0]                       m_tdata,
    input  logic [2:0]                        m_tuser,
    input  logic                              m_tlast,
    output int                                failures,
    output int                                pending_results
);
    import u2u_pkg::*;

    logic [UNIT_W-1:0] unit_limit      = LIMIT_RESET;
    logic [UNIT_W-1:0] substitute_unit = SUBST_RESET;

    logic [1:0]        bytes_pending = '0;
    logic [UNIT_W-1:0] partial_unit  = '0;
    logic              sequence_bad  = 1'b0;
    logic              halted        = 1'b0;
    logic [UNIT_W-1:0] unit_count    = '0;

    result_t expected_units[$];

    initial failures = 0;
    initial pending_results = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
        failures = failures + 1;
    endtask

    task automatic clear_text_state;
        bytes_pending = '0;
        partial_unit  = '0;
        sequence_bad  = 1'b0;
        halted        = 1'b0;
        unit_count    = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic              have;
        logic              sub;
        logic [UNIT_W-1:0] unit;
        result_t           outcome;
        have = 1'b0;
        sub  = 1'b0;
        unit = '0;
        if (!halted)
        begin
            if (bytes_pending == 2'd0)
            begin
                if (unit_count >= unit_limit)
                    halted = 1'b1;
                else if (b < 8'h80)
                begin
                    unit = {8'h00, b};
                    have = 1'b1;
                end
                else if ((b & 8'hE0) == 8'hC0)
                begin
                    partial_unit  = {11'd0, b[4:0]};
                    bytes_pending = 2'd1;
                    sequence_bad  = 1'b0;
                end
                else if ((b & 8'hF0) == 8'hE0)
                begin
                    partial_unit  = {12'd0, b[3:0]};
                    bytes_pending = 2'd2;
                    sequence_bad  = 1'b0;
                end
                else
                    halted = 1'b1;
            end
            else
            begin
                if ((b & 8'hC0) != 8'h80)
                    sequence_bad = 1'b1;
                partial_unit  = {partial_unit[9:0], b[5:0]};
                bytes_pending = bytes_pending - 2'd1;
                if (bytes_pending == 2'd0)
                begin
                    have = 1'b1;
                    sub  = sequence_bad;
                    unit = sequence_bad ? substitute_unit : partial_unit;
                end
            end
            // A text that ends inside a multi-byte sequence yields the substitute.
            if (!have && last && bytes_pending != 2'd0)
            begin
                have          = 1'b1;
                sub           = 1'b1;
                unit          = substitute_unit;
                bytes_pending = 2'd0;
            end
            if (have)
            begin
                unit_count = unit_count + 1'b1;
                if (unit_count >= unit_limit)
                    halted = 1'b1;
            end
        end
        if (have || last)
        begin
            outcome.has_unit     = have;
            outcome.code_unit    = have ? unit : '0;
            outcome.substituted  = sub;
            outcome.stopped      = halted;
            outcome.end_of_text  = last;
            outcome.units_so_far = unit_count;
            expected_units.push_back(outcome);
        end
        if (last)
            clear_text_state();
    endtask

    task automatic check_result;
        result_t want;
        if (expected_units.size() == 0)
        begin
            report_mismatch("result with nothing expected", m_tdata, 32'd0);
            return;
        end
        want = expected_units.pop_front();
        if (m_tuser[0] !== want.has_unit)
            report_mismatch("has_unit", {31'd0, m_tuser[0]}, {31'd0, want.has_unit});
        if (m_tdata[15:0] !== want.code_unit)
            report_mismatch("code_unit", {16'd0, m_tdata[15:0]}, {16'd0, want.code_unit});
        if (m_tuser[1] !== want.substituted)
            report_mismatch("substituted", {31'd0, m_tuser[1]}, {31'd0, want.substituted});
        if (m_tuser[2] !== want.stopped)
            report_mismatch("stopped", {31'd0, m_tuser[2]}, {31'd0, want.stopped});
        if (m_tlast !== want.end_of_text)
            report_mismatch("end_of_text", {31'd0, m_tlast}, {31'd0, want.end_of_text});
        if (m_tdata[31:16] !== want.units_so_far)
            report_mismatch("units_so_far", {16'd0, m_tdata[31:16]},
                            {16'd0, want.units_so_far});
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            unit_limit      = LIMIT_RESET;
            substitute_unit = SUBST_RESET;
            clear_text_state();
            expected_units.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == CFG_ADDR_W'(int'(REG_UNIT_LIMIT) * 4))
                    unit_limit = pwdata[UNIT_W-1:0];
                else if (paddr == CFG_ADDR_W'(int'(REG_SUBSTITUTE) * 4))
                    substitute_unit = pwdata[UNIT_W-1:0];
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
        end
        pending_results <= expected_units.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import u2u_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASE_BYTES     = 145;
    localparam int PHASE_COUNT     = 6;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata  = '0;
    logic                    s_tlast  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [31:0]             m_tdata;
    logic [2:0]              m_tuser;
    logic                    m_tlast;

    int failures;
    int pending_results;
    int holds_requested = 0;
    int burst_left      = 0;
    bit steady_sender   = 1'b0;

    logic [7:0] text_bytes[$];

    utf8_to_ucs2_stream_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ucs2_result_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .failures        (failures),
        .pending_results (pending_results)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : receiver
        int mode;
        int stretch;
        int k;
        int holds_served;
        holds_served = 0;
        forever
        begin
            if (holds_served != holds_requested)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served = holds_served + 1;
            end
            else
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(10, 120);
                for (k = 0; k < stretch && holds_served == holds_requested; k++)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 0);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic write_register(input reg_index_t index, input logic [UNIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(index) * 4);
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        logic [31:0] noise;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            if (!steady_sender && gap > 0)
            begin
                noise = $urandom;
                s_tvalid <= 1'b0;
                s_tdata  <= noise[7:0];
                s_tlast  <= noise[8];
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_text;
        int k;
        for (k = 0; k < text_bytes.size(); k++)
            send_byte(text_bytes[k], k == text_bytes.size() - 1);
    endtask

    task automatic build_text;
        int chars;
        int kind;
        int k;
        logic [31:0] r;
        text_bytes.delete();
        chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        kind  = $urandom_range(0, 99);
        if (kind < 12)
        begin
            for (k = 0; k < chars; k++)
            begin
                r = $urandom;
                text_bytes.push_back(r[7:0]);
            end
        end
        else
        begin
            for (k = 0; k < chars; k++)
            begin
                r = $urandom;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        text_bytes.push_back({1'b0, r[6:0]});
                    end
                    1:
                    begin
                        text_bytes.push_back({3'b110, r[10:6]});
                        text_bytes.push_back({2'b10, r[5:0]});
                    end
                    default:
                    begin
                        text_bytes.push_back({4'b1110, r[15:12]});
                        text_bytes.push_back({2'b10, r[11:6]});
                        text_bytes.push_back({2'b10, r[5:0]});
                    end
                endcase
            end
            r = $urandom;
            if (kind >= 70 && kind < 85)
                text_bytes[$urandom_range(0, text_bytes.size() - 1)] = r[7:0];
            else if (kind >= 85 && kind < 93 && text_bytes.size() > 1)
                void'(text_bytes.pop_back());
            else if (kind >= 93)
                text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
                    r[8] ? {2'b10, r[5:0]} : {4'hF, r[3:0]};
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic directed_texts;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hE4, 1'b0);
        send_byte(8'h88, 1'b1);
        send_byte(8'hC5, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    initial
    begin : stimulus
        int phase;
        int sent;
        int k;
        logic [31:0] r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_texts();
        drain();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            r = $urandom;
            case (phase)
                0:
                begin
                    write_register(REG_UNIT_LIMIT, 16'd1);
                    write_register(REG_SUBSTITUTE, 16'h0000);
                end
                1:
                begin
                    write_register(REG_SUBSTITUTE, 16'hFFFF);
                    write_register(REG_UNIT_LIMIT, 16'hFFFF);
                end
                2:
                begin
                    write_register(REG_UNIT_LIMIT, 16'd2);
                    write_register(REG_SUBSTITUTE, r[15:0]);
                end
                3:
                begin
                    write_register(REG_UNIT_LIMIT, 16'($urandom_range(3, 12)));
                    write_register(REG_SUBSTITUTE, r[15:0]);
                end
                4:
                begin
                    write_register(REG_UNIT_LIMIT, 16'($urandom_range(1, 65535)));
                    write_register(REG_SUBSTITUTE, r[15:0]);
                end
                default:
                begin
                    write_register(REG_UNIT_LIMIT, 16'd5);
                    write_register(REG_SUBSTITUTE, r[15:0]);
                end
            endcase

            if (phase == 4)
            begin
                // The receiver holds off while a long text keeps the input offered.
                holds_requested <= holds_requested + 1;
                steady_sender = 1'b1;
                text_bytes.delete();
                for (k = 0; k < 60; k++)
                begin
                    r = $urandom;
                    text_bytes.push_back({1'b0, r[6:0]});
                end
                send_text();
                steady_sender = 1'b0;
            end

            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_text();
                send_text();
                sent = sent + text_bytes.size();
            end
            drain();
        end

        if (failures == 0 && pending_results == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
